// ===== sv/mh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh_pkg
// Shared types, widths and the arctangent table of the heading pipeline.
// ----------------------------------------------------------------------------
package mh_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int STAGE_W       = 5;

  localparam int RAW_W   = 16;
  localparam int DIFF_W  = 17;
  localparam int SCALE_W = 16;
  localparam int PROD_W  = 34;
  localparam int CAL_W   = 18;
  localparam int GAIN_SH = 15;
  localparam int GUARD_SH = 8;
  localparam int VEC_W   = 29;
  localparam int ANG_W   = 24;
  localparam int HEAD_W  = 16;
  localparam int HOFF_W  = 15;

  localparam int CAL_MAX = 131071;
  localparam int CAL_MIN = -131072;
  localparam int QUARTER_TURN = 1647099;
  localparam int ROUND_HALF = 128;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd30147;

  typedef enum logic [2:0] {
    REG_X_OFF    = 3'd0,
    REG_Y_OFF    = 3'd1,
    REG_Z_OFF    = 3'd2,
    REG_SCALE    = 3'd3,
    REG_HEAD_OFF = 3'd4
  } reg_idx_t;

  typedef logic signed [CAL_W-1:0] cal_t;
  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  typedef struct packed {
    vec_t re;
    vec_t im;
    ang_t acc;
    logic zero;
    cal_t cal_x;
    cal_t cal_y;
    cal_t cal_z;
  } cordic_word_t;

  // atan(2^-i) in units of 2^-20 rad
  function automatic ang_t atan_lut(input logic [STAGE_W-1:0] idx);
    ang_t a;
    case (idx)
      5'd0:    a = 24'sd823550;
      5'd1:    a = 24'sd486170;
      5'd2:    a = 24'sd256879;
      5'd3:    a = 24'sd130396;
      5'd4:    a = 24'sd65451;
      5'd5:    a = 24'sd32757;
      5'd6:    a = 24'sd16383;
      5'd7:    a = 24'sd8192;
      5'd8:    a = 24'sd4096;
      5'd9:    a = 24'sd2048;
      5'd10:   a = 24'sd1024;
      5'd11:   a = 24'sd512;
      5'd12:   a = 24'sd256;
      5'd13:   a = 24'sd128;
      5'd14:   a = 24'sd64;
      5'd15:   a = 24'sd32;
      5'd16:   a = 24'sd16;
      5'd17:   a = 24'sd8;
      5'd18:   a = 24'sd4;
      5'd19:   a = 24'sd2;
      5'd20:   a = 24'sd1;
      5'd21:   a = 24'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== sv/magnetometer_heading_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_heading_core
// Calibrates one magnetometer sample and returns its compass heading.
// ----------------------------------------------------------------------------
// Takes one word (six big-endian sample bytes) per clock and returns one word
// per clock while out_stall is low. The pipeline is three front stages
// (offset, gain and saturation, quarter-turn pre-rotation), one cell per
// CORDIC micro-rotation, and the output register that rounds the angle and
// adds heading_offset. Every stage holds its word under out_stall and empty
// stages keep filling, so in_stall rises only when the whole pipeline is full.
// heading is atan2(cal_x, cal_y) in 2^-12 rad, unwrapped; it equals
// heading_offset when cal_x and cal_y are both zero. Registers sit at byte
// addresses 0, 4, 8, 12, 16; the user must write them only while idle (unenforced).
// ----------------------------------------------------------------------------
module magnetometer_heading_core
  import mh_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_x_high,
  input  logic [7:0]               in_x_low,
  input  logic [7:0]               in_y_high,
  input  logic [7:0]               in_y_low,
  input  logic [7:0]               in_z_high,
  input  logic [7:0]               in_z_low,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [HEAD_W-1:0] out_heading,
  output logic signed [CAL_W-1:0]  out_cal_x,
  output logic signed [CAL_W-1:0]  out_cal_y,
  output logic signed [CAL_W-1:0]  out_cal_z,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  logic signed [RAW_W-1:0]  x_off_r, y_off_r, z_off_r;
  logic [SCALE_W-1:0]       scale_r;
  logic signed [HOFF_W-1:0] hoff_r;
  reg_idx_t                 reg_sel;
  logic                     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_off_r <= '0;
      y_off_r <= '0;
      z_off_r <= '0;
      scale_r <= SCALE_RESET;
      hoff_r  <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_X_OFF:    x_off_r <= pwdata[RAW_W-1:0];
        REG_Y_OFF:    y_off_r <= pwdata[RAW_W-1:0];
        REG_Z_OFF:    z_off_r <= pwdata[RAW_W-1:0];
        REG_SCALE:    scale_r <= pwdata[SCALE_W-1:0];
        REG_HEAD_OFF: hoff_r  <= pwdata[HOFF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_X_OFF:    prdata = DATA_W'($unsigned(x_off_r));
      REG_Y_OFF:    prdata = DATA_W'($unsigned(y_off_r));
      REG_Z_OFF:    prdata = DATA_W'($unsigned(z_off_r));
      REG_SCALE:    prdata = DATA_W'(scale_r);
      REG_HEAD_OFF: prdata = DATA_W'($unsigned(hoff_r));
      default:      prdata = '0;
    endcase
  end

  cordic_word_t                 chain_word  [0:CORDIC_STAGES];
  logic [CORDIC_STAGES:0]       chain_valid;
  logic [CORDIC_STAGES:0]       chain_ready;
  logic                         front_ready;

  mh_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .x_high    (in_x_high),
    .x_low     (in_x_low),
    .y_high    (in_y_high),
    .y_low     (in_y_low),
    .z_high    (in_z_high),
    .z_low     (in_z_low),
    .x_off     (x_off_r),
    .y_off     (y_off_r),
    .z_off     (z_off_r),
    .scale     (scale_r),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_word  (chain_word[0])
  );

  assign in_stall = !front_ready;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    mh_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (STAGE_W'(g)),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_word   (chain_word[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_word  (chain_word[g+1])
    );
  end

  // output register: round the angle to 2^-12 rad and add the offset
  cordic_word_t              last_word;
  ang_t                      acc_rnd;
  logic signed [HEAD_W-1:0]  atan_part;
  logic signed [HEAD_W-1:0]  heading_nxt;
  logic                      out_valid_r;
  logic signed [HEAD_W-1:0]  heading_r;
  cal_t                      cal_x_r, cal_y_r, cal_z_r;
  logic                      out_ready;

  assign last_word   = chain_word[CORDIC_STAGES];
  assign acc_rnd     = last_word.acc + ang_t'(ROUND_HALF);
  assign atan_part   = last_word.zero ? '0 : acc_rnd[GUARD_SH +: HEAD_W];
  assign heading_nxt = atan_part + HEAD_W'(hoff_r);

  assign out_ready                  = !out_valid_r || !out_stall;
  assign chain_ready[CORDIC_STAGES] = out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= chain_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && chain_valid[CORDIC_STAGES]) begin
      heading_r <= heading_nxt;
      cal_x_r   <= last_word.cal_x;
      cal_y_r   <= last_word.cal_y;
      cal_z_r   <= last_word.cal_z;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_heading = heading_r;
  assign out_cal_x   = cal_x_r;
  assign out_cal_y   = cal_y_r;
  assign out_cal_z   = cal_z_r;

endmodule

// ===== sv/mh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh_front
// Assembles the three axes, removes offsets, applies gain with saturation and
// turns the (y, x) vector into the right half plane for the CORDIC chain.
// ----------------------------------------------------------------------------
module mh_front
  import mh_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               x_high,
  input  logic [7:0]               x_low,
  input  logic [7:0]               y_high,
  input  logic [7:0]               y_low,
  input  logic [7:0]               z_high,
  input  logic [7:0]               z_low,
  input  logic signed [RAW_W-1:0]  x_off,
  input  logic signed [RAW_W-1:0]  y_off,
  input  logic signed [RAW_W-1:0]  z_off,
  input  logic [SCALE_W-1:0]       scale,
  output logic                     out_valid,
  input  logic                     out_ready,
  output cordic_word_t             out_word
);

  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(CAL_MAX);
  localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(CAL_MIN);

  function automatic cal_t sat_cal(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    cal_t r;
    s = p >>> GAIN_SH;
    if (s > SAT_HI) begin
      r = cal_t'(CAL_MAX);
    end else if (s < SAT_LO) begin
      r = cal_t'(CAL_MIN);
    end else begin
      r = s[CAL_W-1:0];
    end
    return r;
  endfunction

  function automatic vec_t to_vec(input cal_t c);
    return vec_t'($signed({c, {GUARD_SH{1'b0}}}));
  endfunction

  logic                     v1_r, v2_r, v3_r;
  logic                     rdy1, rdy2, rdy3;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt, dz_nxt;
  cal_t                     cx_r, cy_r, cz_r;
  logic signed [PROD_W-1:0] px, py, pz;
  cordic_word_t             w_r, w_nxt;
  vec_t                     vx, vy;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: assemble and remove offset
  assign dx_nxt = DIFF_W'($signed({x_high, x_low})) - DIFF_W'(x_off);
  assign dy_nxt = DIFF_W'($signed({y_high, y_low})) - DIFF_W'(y_off);
  assign dz_nxt = DIFF_W'($signed({z_high, z_low})) - DIFF_W'(z_off);

  // stage 2: gain and saturation
  assign px = dx_r * $signed({1'b0, scale});
  assign py = dy_r * $signed({1'b0, scale});
  assign pz = dz_r * $signed({1'b0, scale});

  // stage 3: quarter-turn pre-rotation when the real part is negative
  assign vx = to_vec(cx_r);
  assign vy = to_vec(cy_r);

  always_comb begin
    w_nxt       = '0;
    w_nxt.cal_x = cx_r;
    w_nxt.cal_y = cy_r;
    w_nxt.cal_z = cz_r;
    w_nxt.zero  = (cx_r == '0) && (cy_r == '0);
    w_nxt.re    = vy;
    w_nxt.im    = vx;
    w_nxt.acc   = '0;
    if (vy < 0) begin
      if (vx >= 0) begin
        w_nxt.re  = vx;
        w_nxt.im  = -vy;
        w_nxt.acc = ang_t'(QUARTER_TURN);
      end else begin
        w_nxt.re  = -vx;
        w_nxt.im  = vy;
        w_nxt.acc = -ang_t'(QUARTER_TURN);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      dz_r <= dz_nxt;
    end
    if (rdy2 && v1_r) begin
      cx_r <= sat_cal(px);
      cy_r <= sat_cal(py);
      cz_r <= sat_cal(pz);
    end
    if (rdy3 && v2_r) begin
      w_r <= w_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_word  = w_r;

endmodule

// ===== sv/mh_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh_cell
// One vectoring CORDIC micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
module mh_cell
  import mh_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [STAGE_W-1:0]  stage_idx,
  input  logic                in_valid,
  output logic                in_ready,
  input  cordic_word_t        in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output cordic_word_t        out_word
);

  logic         valid_r;
  cordic_word_t word_r, word_nxt;
  vec_t         dr, di;
  ang_t         step;

  assign dr   = in_word.im >>> stage_idx;
  assign di   = in_word.re >>> stage_idx;
  assign step = atan_lut(stage_idx);

  always_comb begin
    word_nxt = in_word;
    // stages past the table leave the vector alone
    if (stage_idx < STAGE_W'(TABLE_LEN)) begin
      if (in_word.im < 0) begin
        word_nxt.re  = in_word.re - dr;
        word_nxt.im  = in_word.im + di;
        word_nxt.acc = in_word.acc - step;
      end else begin
        word_nxt.re  = in_word.re + dr;
        word_nxt.im  = in_word.im - di;
        word_nxt.acc = in_word.acc + step;
      end
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// ===== sv/mh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh_checker
// Port-level checks on the heading core, bound to the top level.
// ----------------------------------------------------------------------------
module mh_checker
  import mh_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [HEAD_W-1:0] out_heading,
  input logic signed [CAL_W-1:0]  out_cal_x,
  input logic signed [CAL_W-1:0]  out_cal_y,
  input logic signed [CAL_W-1:0]  out_cal_z,
  input logic                     pready
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // with the output free to move, the pipeline must take a new word
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("in_stall high while output side drains");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_heading)
      && $stable(out_cal_x) && $stable(out_cal_y) && $stable(out_cal_z))
    else $error("stalled result changed");

  // the register port never inserts wait states
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind magnetometer_heading_core mh_checker u_mh_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the magnetometer heading core.
// ----------------------------------------------------------------------------
// Feeds six-byte samples through a queued driver and checks every result word
// against a local calibration and CORDIC atan2 predictor. Runs directed corner
// samples, then random samples under several register settings, with sender
// and receiver idling that changes from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
  import mh_pkg::*;

  localparam int DRAIN_CYCLES = CORDIC_STAGES + 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int CHUNK        = 140;

  typedef struct packed {
    logic [7:0] xh, xl, yh, yl, zh, zl;
  } sample_t;

  typedef struct {
    logic signed [HEAD_W-1:0] heading;
    cal_t                     cal_x;
    cal_t                     cal_y;
    cal_t                     cal_z;
  } heading_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_x_high = '0, in_x_low = '0, in_y_high = '0;
  logic [7:0] in_y_low = '0, in_z_high = '0, in_z_low = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [HEAD_W-1:0] out_heading;
  cal_t                     out_cal_x, out_cal_y, out_cal_z;

  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // register copies used by the predictor
  logic signed [RAW_W-1:0]  x_off_r = '0, y_off_r = '0, z_off_r = '0;
  logic [SCALE_W-1:0]       gain_r = SCALE_RESET;
  logic signed [HOFF_W-1:0] head_off_r = '0;

  longint atan_q20 [0:23] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 1, 0, 0
  };

  sample_t       pending_samples[$];
  heading_word_t expected_words[$];

  int send_idle_pct = 19;
  int recv_idle_pct = 71;
  int fail_count = 0;
  int cycle_count = 0;

  magnetometer_heading_core uut (
    .clk, .rst_n,
    .in_valid, .in_stall,
    .in_x_high, .in_x_low, .in_y_high, .in_y_low, .in_z_high, .in_z_low,
    .out_valid, .out_stall,
    .out_heading, .out_cal_x, .out_cal_y, .out_cal_z,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk = ~clk;

  function automatic cal_t calibrate_axis(logic [7:0] hi, logic [7:0] lo,
                                          logic signed [RAW_W-1:0] off);
    longint raw;
    longint scaled;
    raw = longint'($signed({hi, lo}));
    scaled = ((raw - longint'(off)) * longint'(gain_r)) >>> GAIN_SH;
    if (scaled > CAL_MAX) scaled = CAL_MAX;
    if (scaled < CAL_MIN) scaled = CAL_MIN;
    return cal_t'(scaled);
  endfunction

  // vectoring CORDIC, angle in 2^-20 rad, rounded to 2^-12 rad
  function automatic longint atan2_q12(cal_t num, cal_t den);
    longint re, im, acc, t, dr, di;
    re = longint'(den) * 256;
    im = longint'(num) * 256;
    acc = 0;
    if (num == 0 && den == 0) return 0;
    if (re < 0) begin
      if (im >= 0) begin
        t = re; re = im; im = -t;
        acc = QUARTER_TURN;
      end else begin
        t = re; re = -im; im = t;
        acc = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dr = im >>> i;
      di = re >>> i;
      if (im < 0) begin
        re = re - dr;
        im = im + di;
        acc -= atan_q20[i];
      end else begin
        re = re + dr;
        im = im - di;
        acc += atan_q20[i];
      end
    end
    return (acc + ROUND_HALF) >>> GUARD_SH;
  endfunction

  function automatic heading_word_t predict_heading(sample_t s);
    heading_word_t w;
    longint h;
    w.cal_x = calibrate_axis(s.xh, s.xl, x_off_r);
    w.cal_y = calibrate_axis(s.yh, s.yl, y_off_r);
    w.cal_z = calibrate_axis(s.zh, s.zl, z_off_r);
    h = atan2_q12(w.cal_x, w.cal_y) + longint'(head_off_r);
    w.heading = h[HEAD_W-1:0];
    return w;
  endfunction

  // launch a new word only when the current one is gone or absent
  always @(posedge clk) begin : sample_driver
    sample_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_words.push_back(predict_heading({in_x_high, in_x_low, in_y_high,
                                                  in_y_low, in_z_high, in_z_low}));
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s = pending_samples.pop_front();
          in_x_high <= s.xh;
          in_x_low  <= s.xl;
          in_y_high <= s.yh;
          in_y_low  <= s.yl;
          in_z_high <= s.zh;
          in_z_low  <= s.zl;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : heading_monitor
    heading_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: heading %0d", out_heading);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_heading !== want.heading) begin
            $error("heading: expected %0d, got %0d", want.heading, out_heading);
            fail_count++;
          end
          if (out_cal_x !== want.cal_x) begin
            $error("cal_x: expected %0d, got %0d", want.cal_x, out_cal_x);
            fail_count++;
          end
          if (out_cal_y !== want.cal_y) begin
            $error("cal_y: expected %0d, got %0d", want.cal_y, out_cal_y);
            fail_count++;
          end
          if (out_cal_z !== want.cal_z) begin
            $error("cal_z: expected %0d, got %0d", want.cal_z, out_cal_z);
            fail_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    pending_samples.push_back({x, y, z});
  endtask

  // mix of uniform values, values near or at the offset, and extremes
  function automatic logic [15:0] pick_axis(logic signed [RAW_W-1:0] off);
    int mode;
    logic [15:0] v;
    mode = $urandom_range(99);
    if (mode < 50) begin
      v = 16'($urandom);
    end else if (mode < 70) begin
      v = off + 16'($urandom_range(6)) - 16'd3;
    end else if (mode < 85) begin
      case ($urandom_range(3))
        0:       v = 16'h7FFF;
        1:       v = 16'h8000;
        2:       v = 16'h0000;
        default: v = 16'hFFFF;
      endcase
    end else begin
      v = off;
    end
    return v;
  endfunction

  task automatic add_random_samples(int n);
    repeat (n) push_sample(pick_axis(x_off_r), pick_axis(y_off_r), pick_axis(z_off_r));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // setup then access; upper data bits carry noise the register must drop
  task automatic reg_write(reg_idx_t idx, logic [15:0] val);
    logic [DATA_W-1:0] word;
    word = $urandom;
    if (idx == REG_HEAD_OFF) word[HOFF_W-1:0] = val[HOFF_W-1:0];
    else word[15:0] = val;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_X_OFF:    x_off_r = val;
      REG_Y_OFF:    y_off_r = val;
      REG_Z_OFF:    z_off_r = val;
      REG_SCALE:    gain_r = val;
      REG_HEAD_OFF: head_off_r = val[HOFF_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic write_all(logic [15:0] xo, logic [15:0] yo, logic [15:0] zo,
                           logic [15:0] gain, logic [15:0] hoff);
    reg_write(REG_X_OFF, xo);
    reg_write(REG_Y_OFF, yo);
    reg_write(REG_Z_OFF, zo);
    reg_write(REG_SCALE, gain);
    reg_write(REG_HEAD_OFF, hoff);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: zero vector, quarter-turn cases, x zero with y negative
    push_sample(16'h0000, 16'h0000, 16'h0000);
    push_sample(16'h0000, 16'hFFFB, 16'h0001);
    push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_sample(16'h8000, 16'h8000, 16'h8000);
    push_sample(16'd100, -16'sd100, 16'h0000);
    push_sample(-16'sd100, -16'sd100, 16'hFFFF);
    push_sample(16'hFFFF, 16'h0000, 16'h0000);
    push_sample(16'h0001, 16'h0000, 16'h0000);
    push_sample(16'h0000, 16'h0001, 16'h0000);
    push_sample(16'h00FF, 16'hFF00, 16'h5AA5);
    push_sample(16'hA55A, 16'h0F0F, 16'hF0F0);
    wait_drained();

    // widest offsets and gain; one sample lands on both axes zero
    write_all(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd12868);
    push_sample(16'h7FFF, 16'h8000, 16'h7FFF);
    push_sample(16'h8000, 16'h8000, 16'h8000);
    push_sample(16'h8000, 16'h7FFF, 16'h8000);
    push_sample(16'hFFFF, 16'h7FFF, 16'h0000);
    wait_drained();

    // zero gain: heading is the offset alone
    write_all(16'h1234, 16'hEDCB, 16'h0000, 16'h0000, -16'sd12868);
    push_sample(16'h7FFF, 16'h8000, 16'h1234);
    push_sample(16'h0000, 16'hFFFF, 16'h8000);
    wait_drained();

    write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
    add_random_samples(CHUNK);
    wait_drained();

    // extremes, with a full drain halfway so the sender sits idle
    write_all(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h4000);
    add_random_samples(CHUNK / 2);
    wait_drained();
    add_random_samples(CHUNK / 2);
    wait_drained();

    send_idle_pct = 71;
    recv_idle_pct = 19;
    write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'h8000,
              16'($urandom));
    add_random_samples(CHUNK);
    wait_drained();

    write_all(16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom_range(15)), 16'h3FFF);
    add_random_samples(CHUNK);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
    add_random_samples(CHUNK);
    wait_drained();

    write_all(16'h0000, 16'h0000, 16'h0000, SCALE_RESET, 16'h0000);
    add_random_samples(CHUNK);
    wait_drained();

    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/mh_pkg.sv
sv/mh_front.sv
sv/mh_cell.sv
sv/magnetometer_heading_core.sv
sv/mh_checker.sv
tb/sv/testbench.sv
